@@ rtl/cbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbsm_pkg
// Types and constants shared by the cartridge bank switch mapper.
// ----------------------------------------------------------------------------
package cbsm_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned BANK_W      = 4;
    localparam int unsigned OFFSET_W    = 20;
    localparam int unsigned ROM_SIZE_W  = 21;
    localparam int unsigned TYPE_W      = 3;
    localparam int unsigned BANK_SHIFT  = 14;      // 16 KiB banks
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned PDATA_W     = 32;

    // Window base addresses
    localparam logic [ADDR_W-1:0] BASE_NONE  = 16'h0000;
    localparam logic [ADDR_W-1:0] BASE_LOW   = 16'h4000;   // two-bank window
    localparam logic [ADDR_W-1:0] BASE_MID   = 16'h8000;   // banked window
    localparam logic [ADDR_W-1:0] BASE_EIGHT = 16'hA000;   // eight-bank window

    // Bus decode constants
    localparam logic [ADDR_W-1:0]     TWO_BANK_ADDR = 16'h8000;
    localparam logic [8:0]            EIGHT_HI_BITS = 9'h1FF;   // address >= 0xFF80
    localparam logic [DATA_W-1:0]     BANK_DATA_LIM = 8'd9;
    localparam logic [ROM_SIZE_W-1:0] SMALL_ROM     = 21'h010000; // 64 KiB

    // Register indexes (paddr[2])
    localparam logic REG_MAPPER_TYPE = 1'b0;
    localparam logic REG_ROM_SIZE    = 1'b1;

    typedef enum logic [TYPE_W-1:0] {
        MT_FLAT         = 3'd0,
        MT_FLAT_RAM     = 3'd1,
        MT_BANKED       = 3'd2,
        MT_BANKED_LARGE = 3'd3,
        MT_BANKED_ROM   = 3'd4,
        MT_BANKED_RAM   = 3'd5,
        MT_TWO_BANK     = 3'd6,
        MT_EIGHT_BANK   = 3'd7
    } t_mapper_type;

    typedef struct packed {
        logic                remap;
        logic [ADDR_W-1:0]   window_base;
        logic [OFFSET_W-1:0] rom_offset;
        logic [BANK_W-1:0]   bank_now;
    } t_dec_res;

endpackage

@@ rtl/cbsm_regs.sv @@
// ----------------------------------------------------------------------------
// cbsm_regs
// APB-style configuration registers: mapper type and ROM size.
// ----------------------------------------------------------------------------
module cbsm_regs
    import cbsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output t_mapper_type          o_mapper_type,
    output logic [ROM_SIZE_W-1:0] o_rom_size
);

    t_mapper_type          r_mapper_type;
    logic [ROM_SIZE_W-1:0] r_rom_size;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper_type <= MT_FLAT;
            r_rom_size    <= '0;
        end else if (wr_en) begin
            if (paddr[2] == REG_MAPPER_TYPE) begin
                r_mapper_type <= t_mapper_type'(pwdata[TYPE_W-1:0]);
            end else begin
                r_rom_size <= pwdata[ROM_SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_ROM_SIZE) begin
            prdata = {{(PDATA_W-ROM_SIZE_W){1'b0}}, r_rom_size};
        end else begin
            prdata = {{(PDATA_W-TYPE_W){1'b0}}, r_mapper_type};
        end
    end

    assign o_mapper_type = r_mapper_type;
    assign o_rom_size    = r_rom_size;

endmodule

@@ rtl/cbsm_decode.sv @@
// ----------------------------------------------------------------------------
// cbsm_decode
// Decodes one bus write into a bank select and checks it against ROM size.
// ----------------------------------------------------------------------------
module cbsm_decode
    import cbsm_pkg::*;
(
    input  t_mapper_type          i_mapper_type,
    input  logic [ROM_SIZE_W-1:0] i_rom_size,
    input  logic [ADDR_W-1:0]     i_bus_address,
    input  logic [DATA_W-1:0]     i_bus_data,
    input  logic [BANK_W-1:0]     i_cur_bank,
    output t_dec_res              o_res
);

    logic                      hit;
    logic                      plain;
    logic [BANK_W-1:0]         bank;
    logic [BANK_W-1:0]         eff;
    logic [ADDR_W-1:0]         base;
    logic                      in_win;
    logic                      data_ok;
    logic [OFFSET_W-1:0]       off;
    logic                      fits;

    assign in_win  = (i_bus_address[15:14] == 2'b10);
    assign data_ok = (i_bus_data < BANK_DATA_LIM);

    always_comb begin
        hit   = 1'b0;
        plain = 1'b0;
        bank  = '0;
        base  = BASE_NONE;
        unique case (i_mapper_type)
            MT_FLAT, MT_FLAT_RAM: begin
                hit = 1'b0;
            end
            MT_BANKED, MT_BANKED_ROM, MT_BANKED_RAM: begin
                hit   = in_win & data_ok;
                plain = 1'b1;
                bank  = i_bus_data[BANK_W-1:0];
                base  = BASE_MID;
            end
            MT_BANKED_LARGE: begin
                hit  = in_win & data_ok;
                bank = i_bus_data[BANK_W-1:0] + BANK_W'(1);
                base = BASE_MID;
            end
            MT_TWO_BANK: begin
                hit  = (i_bus_address == TWO_BANK_ADDR) &&
                       (i_bus_data == 8'd1 || i_bus_data == 8'd2);
                bank = i_bus_data[BANK_W-1:0] - BANK_W'(1);
                base = BASE_LOW;
            end
            MT_EIGHT_BANK: begin
                hit  = (i_bus_address[15:7] == EIGHT_HI_BITS);
                bank = {1'b0, i_bus_address[2:0]};
                base = BASE_EIGHT;
            end
        endcase
    end

    // small ROMs only see the low two bank bits on the plain banked types
    assign eff  = (plain && (i_rom_size <= SMALL_ROM)) ? {2'b00, bank[1:0]} : bank;
    assign off  = {{(OFFSET_W-BANK_W-BANK_SHIFT){1'b0}}, eff, {BANK_SHIFT{1'b0}}};
    assign fits = ({1'b0, off} < i_rom_size);

    always_comb begin
        if (hit && fits) begin
            o_res.remap       = 1'b1;
            o_res.window_base = base;
            o_res.rom_offset  = off;
            o_res.bank_now    = bank;
        end else begin
            o_res.remap       = 1'b0;
            o_res.window_base = BASE_NONE;
            o_res.rom_offset  = '0;
            o_res.bank_now    = i_cur_bank;
        end
    end

endmodule

@@ rtl/cartridge_bank_switch_mapper.sv @@
// ----------------------------------------------------------------------------
// cartridge_bank_switch_mapper
// Cartridge ROM bank switching decoder for CPU bus writes.
// ----------------------------------------------------------------------------
// Each accepted bus write gives exactly one result item, passing through the
// input register, the single decode stage and the result register. A new
// write is accepted every cycle, one item per clock, unless both registers
// are full and the output side is not ready. The held bank updates as an item
// enters the result register, so back-to-back writes see the bank left by the
// one before. The user must write mapper type and ROM size through the APB
// port only while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_mapper
    import cbsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // bus write in
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ADDR_W-1:0]     i_bus_address,
    input  logic [DATA_W-1:0]     i_bus_data,
    // result out
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_remap,
    output logic [ADDR_W-1:0]     o_window_base,
    output logic [OFFSET_W-1:0]   o_rom_offset,
    output logic [BANK_W-1:0]     o_bank_now
);

    t_mapper_type          mapper_type;
    logic [ROM_SIZE_W-1:0] rom_size;

    logic                  r_in_valid;
    logic [ADDR_W-1:0]     r_in_addr;
    logic [DATA_W-1:0]     r_in_data;
    logic                  r_out_valid;
    t_dec_res              r_out;
    logic [BANK_W-1:0]     r_bank;

    t_dec_res              dec_res;
    logic                  advance;
    logic                  in_take;

    cbsm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_mapper_type (mapper_type),
        .o_rom_size    (rom_size)
    );

    cbsm_decode u_decode (
        .i_mapper_type (mapper_type),
        .i_rom_size    (rom_size),
        .i_bus_address (r_in_addr),
        .i_bus_data    (r_in_data),
        .i_cur_bank    (r_bank),
        .o_res         (dec_res)
    );

    // result register free or draining this cycle
    assign advance = ~r_out_valid | i_ready;
    assign o_ready = ~r_in_valid | advance;
    assign in_take = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_bank <= dec_res.bank_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_addr <= i_bus_address;
            r_in_data <= i_bus_data;
        end
        if (advance && r_in_valid) begin
            r_out <= dec_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_remap       = r_out.remap;
    assign o_window_base = r_out.window_base;
    assign o_rom_offset  = r_out.rom_offset;
    assign o_bank_now    = r_out.bank_now;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cartridge bank switch mapper. A short table of
// bus writes covers the decode corners of each mapper type. Random bus writes
// follow, run under a series of mapper type and ROM size settings. Each result
// item is checked against the table row or an independent decode of the write.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cbsm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned WIN_LO      = 32768;   // banked window, first address
    localparam int unsigned WIN_END     = 49152;   // banked window, one past last
    localparam int unsigned EIGHT_LO    = 65408;   // eight-bank hotspot start
    localparam int unsigned BANK_BYTES  = 16384;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic                is_cfg;
        logic                reg_sel;
        logic [PDATA_W-1:0]  value;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic                typed;
        t_dec_res            res;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [ADDR_W-1:0]    i_bus_address = '0;
    logic [DATA_W-1:0]    i_bus_data = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_remap;
    logic [ADDR_W-1:0]    o_window_base;
    logic [OFFSET_W-1:0]  o_rom_offset;
    logic [BANK_W-1:0]    o_bank_now;

    // bench copy of the mapper configuration and held bank
    t_mapper_type          cfg_type = MT_FLAT;
    logic [ROM_SIZE_W-1:0] cfg_rom  = '0;
    logic [BANK_W-1:0]     held_bank = '0;

    t_dec_res    pending_results[$];
    logic        cur_typed = 1'b0;
    t_dec_res    cur_exp = '0;
    logic        calm = 1'b0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    t_step       walk_rows[$];

    cartridge_bank_switch_mapper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_bus_address (i_bus_address),
        .i_bus_data    (i_bus_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_remap       (o_remap),
        .o_window_base (o_window_base),
        .o_rom_offset  (o_rom_offset),
        .o_bank_now    (o_bank_now)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Decode of one bus write under the given setting and held bank.
    function automatic t_dec_res decode_write(input logic [ADDR_W-1:0] addr,
                                              input logic [DATA_W-1:0] data,
                                              input t_mapper_type mtype,
                                              input logic [ROM_SIZE_W-1:0] rom,
                                              input logic [BANK_W-1:0] bank_in);
        t_dec_res    res;
        logic        hit;
        logic        plain;
        int unsigned bank;
        int unsigned eff;
        int unsigned off;
        logic [ADDR_W-1:0] base;
        hit   = 1'b0;
        plain = 1'b0;
        bank  = 0;
        base  = BASE_NONE;
        case (mtype)
            MT_BANKED, MT_BANKED_ROM, MT_BANKED_RAM: begin
                if (addr >= WIN_LO && addr < WIN_END && data < 9) begin
                    hit   = 1'b1;
                    plain = 1'b1;
                    bank  = 32'(data);
                    base  = BASE_MID;
                end
            end
            MT_BANKED_LARGE: begin
                if (addr >= WIN_LO && addr < WIN_END && data < 9) begin
                    hit  = 1'b1;
                    bank = data + 1;
                    base = BASE_MID;
                end
            end
            MT_TWO_BANK: begin
                if (addr == TWO_BANK_ADDR && (data == 1 || data == 2)) begin
                    hit  = 1'b1;
                    bank = data - 1;
                    base = BASE_LOW;
                end
            end
            MT_EIGHT_BANK: begin
                if (addr >= EIGHT_LO) begin
                    hit  = 1'b1;
                    bank = addr & 7;
                    base = BASE_EIGHT;
                end
            end
            default: ;
        endcase
        res = '0;
        res.bank_now = bank_in;
        if (hit) begin
            eff = bank;
            // small ROMs only see the low two bank bits on plain banked types
            if (plain && rom <= SMALL_ROM)
                eff = eff & 3;
            off = eff * BANK_BYTES;
            if (off < rom) begin
                res.remap       = 1'b1;
                res.window_base = base;
                res.rom_offset  = off[OFFSET_W-1:0];
                res.bank_now    = bank[BANK_W-1:0];
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_dec_res want;
        t_dec_res pred;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result item: remap=%0d base=%h off=%h bank=%0d",
                                 o_remap, o_window_base, o_rom_offset, o_bank_now);
                end else begin
                    want = pending_results.pop_front();
                    if (o_remap !== want.remap || o_window_base !== want.window_base ||
                        o_rom_offset !== want.rom_offset || o_bank_now !== want.bank_now) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_REPORTS)
                            $display("mismatch remap/base/off/bank: exp %0d/%h/%h/%0d %s",
                                     want.remap, want.window_base, want.rom_offset,
                                     want.bank_now,
                                     $sformatf("got %0d/%h/%h/%0d", o_remap,
                                               o_window_base, o_rom_offset, o_bank_now));
                    end
                end
            end
            if (i_valid && o_ready) begin
                pred = decode_write(i_bus_address, i_bus_data, cfg_type, cfg_rom, held_bank);
                held_bank = pred.bank_now;
                pending_results.push_back(cur_typed ? cur_exp : pred);
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
    end

    function automatic t_step cfg_row(input logic reg_sel, input int unsigned value);
        t_step s;
        s = '0;
        s.is_cfg  = 1'b1;
        s.reg_sel = reg_sel;
        s.value   = value;
        return s;
    endfunction

    function automatic t_step write_row(input int unsigned addr, input int unsigned data);
        t_step s;
        s = '0;
        s.addr = addr[ADDR_W-1:0];
        s.data = data[DATA_W-1:0];
        return s;
    endfunction

    function automatic t_step checked_row(input int unsigned addr, input int unsigned data,
                                          input logic remap, input int unsigned base,
                                          input int unsigned off, input int unsigned bank);
        t_step s;
        s = write_row(addr, data);
        s.typed           = 1'b1;
        s.res.remap       = remap;
        s.res.window_base = base[ADDR_W-1:0];
        s.res.rom_offset  = off[OFFSET_W-1:0];
        s.res.bank_now    = bank[BANK_W-1:0];
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data,
                              input logic typed, input t_dec_res exp_res);
        while (!calm && $urandom_range(0, 99) < 11) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_bus_address = addr;
        i_bus_data    = data;
        cur_typed     = typed;
        cur_exp       = exp_res;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle;
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write, then read back. Called at a falling edge with no item in flight.
    task automatic cfg_write(input logic reg_sel, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        mask = (reg_sel == REG_ROM_SIZE) ? {{(PDATA_W-ROM_SIZE_W){1'b0}}, {ROM_SIZE_W{1'b1}}}
                                         : {{(PDATA_W-TYPE_W){1'b0}}, {TYPE_W{1'b1}}};
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_sel == REG_ROM_SIZE)
            cfg_rom = value[ROM_SIZE_W-1:0];
        else
            cfg_type = t_mapper_type'(value[TYPE_W-1:0]);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
                $display("register readback mismatch at %h: exp %h got %h",
                         paddr, value & mask, prdata & mask);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic int unsigned pick_rom_size;
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 16384;
            2:       return 32768;
            3:       return 49152;
            4:       return 65536;
            5:       return 65537;
            6:       return 131072;
            7:       return 147456;
            8:       return 1048576;
            9:       return $urandom_range(1, 10) * BANK_BYTES + $urandom_range(0, 2) - 1;
            default: return $urandom_range(0, 1048576);
        endcase
    endfunction

    task automatic send_random_write;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int unsigned       r;
        r    = $urandom_range(0, 99);
        addr = ADDR_W'($urandom_range(0, 65535));
        data = DATA_W'($urandom_range(0, 255));
        case (cfg_type)
            MT_BANKED, MT_BANKED_LARGE, MT_BANKED_ROM, MT_BANKED_RAM: begin
                if (r < 75) begin
                    addr = ADDR_W'($urandom_range(WIN_LO, WIN_END - 1));
                    data = DATA_W'($urandom_range(0, 8));
                end else if (r < 85) begin
                    addr = ($urandom_range(0, 1) != 0) ? ADDR_W'(WIN_LO - 1) : ADDR_W'(WIN_END);
                end
            end
            MT_TWO_BANK: begin
                if (r < 70) begin
                    addr = TWO_BANK_ADDR;
                    data = DATA_W'($urandom_range(1, 2));
                end else if (r < 82) begin
                    addr = TWO_BANK_ADDR;
                end
            end
            MT_EIGHT_BANK: begin
                if (r < 75)
                    addr = ADDR_W'($urandom_range(EIGHT_LO, 65535));
            end
            default: ;
        endcase
        send_write(addr, data, 1'b0, '0);
    endtask

    initial begin
        t_step       row;
        int unsigned rom;
        int unsigned n_items;
        logic        rom_first;

        // after reset: flat, empty ROM
        walk_rows.push_back(checked_row(16'h8000, 0, 1'b0, 0, 0, 0));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_BANKED));
        walk_rows.push_back(checked_row(16'h8000, 1, 1'b0, 0, 0, 0));
        walk_rows.push_back(cfg_row(REG_ROM_SIZE, 131072));
        walk_rows.push_back(checked_row(16'h8000, 0, 1'b1, BASE_MID, 0, 0));
        walk_rows.push_back(checked_row(16'hBFFF, 7, 1'b1, BASE_MID, 114688, 7));
        // offset equal to ROM size is out of range
        walk_rows.push_back(checked_row(16'hBFFF, 8, 1'b0, 0, 0, 7));
        walk_rows.push_back(checked_row(16'h7FFF, 3, 1'b0, 0, 0, 7));
        walk_rows.push_back(checked_row(16'hC000, 3, 1'b0, 0, 0, 7));
        walk_rows.push_back(checked_row(16'h8000, 9, 1'b0, 0, 0, 7));
        walk_rows.push_back(checked_row(16'h8000, 255, 1'b0, 0, 0, 7));
        // 64 KiB ROM: offset masked to two bits, held bank not masked
        walk_rows.push_back(cfg_row(REG_ROM_SIZE, 65536));
        walk_rows.push_back(checked_row(16'h8000, 7, 1'b1, BASE_MID, 49152, 7));
        walk_rows.push_back(checked_row(16'h9000, 8, 1'b1, BASE_MID, 0, 8));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_BANKED_LARGE));
        walk_rows.push_back(cfg_row(REG_ROM_SIZE, 1048576));
        walk_rows.push_back(checked_row(16'h8000, 8, 1'b1, BASE_MID, 147456, 9));
        walk_rows.push_back(checked_row(16'h8000, 0, 1'b1, BASE_MID, 16384, 1));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_TWO_BANK));
        walk_rows.push_back(cfg_row(REG_ROM_SIZE, 32768));
        walk_rows.push_back(checked_row(16'h8000, 1, 1'b1, BASE_LOW, 0, 0));
        walk_rows.push_back(checked_row(16'h8000, 2, 1'b1, BASE_LOW, 16384, 1));
        walk_rows.push_back(checked_row(16'h8000, 3, 1'b0, 0, 0, 1));
        walk_rows.push_back(checked_row(16'h8001, 1, 1'b0, 0, 0, 1));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_EIGHT_BANK));
        walk_rows.push_back(cfg_row(REG_ROM_SIZE, 1048576));
        walk_rows.push_back(checked_row(16'hFF80, 0, 1'b1, BASE_EIGHT, 0, 0));
        walk_rows.push_back(checked_row(16'hFFFF, 255, 1'b1, BASE_EIGHT, 114688, 7));
        walk_rows.push_back(checked_row(16'hFF7F, 0, 1'b0, 0, 0, 7));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_BANKED_ROM));
        walk_rows.push_back(write_row(16'h8000, 8));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_BANKED_RAM));
        walk_rows.push_back(write_row(16'hA000, 5));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_FLAT_RAM));
        walk_rows.push_back(write_row(16'h8000, 1));
        walk_rows.push_back(cfg_row(REG_MAPPER_TYPE, MT_FLAT));
        walk_rows.push_back(write_row(16'hFFFF, 0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (walk_rows[k]) begin
            row = walk_rows[k];
            if (row.is_cfg) begin
                wait_idle();
                cfg_write(row.reg_sel, row.value);
            end else begin
                send_write(row.addr, row.data, row.typed, row.res);
            end
        end

        for (int ph = 0; ph < 25; ph++) begin
            if (ph == 2)
                rom = 0;
            else if (ph == 3 || ph == 7)
                rom = 1048576;
            else
                rom = pick_rom_size();
            wait_idle();
            rom_first = 1'($urandom_range(0, 1));
            if (rom_first)
                cfg_write(REG_ROM_SIZE, rom);
            cfg_write(REG_MAPPER_TYPE, (ph < 8) ? ph : $urandom_range(0, 7));
            if (!rom_first)
                cfg_write(REG_ROM_SIZE, rom);
            calm = (ph >= 12 && ph < 15);
            n_items = (cfg_type == MT_FLAT || cfg_type == MT_FLAT_RAM) ? 20 : 60;
            for (int n = 0; n < n_items; n++)
                send_random_write();
        end

        calm = 1'b0;
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cbsm_pkg.sv
rtl/cbsm_regs.sv
rtl/cbsm_decode.sv
rtl/cartridge_bank_switch_mapper.sv
test/tb_top.sv
